// ----- rtl/mrtl_pkg.sv -----
// shared types, codes and defaults of the mesh route table learner
// no dependencies; used by every module of the block but mrtl_ram
package mrtl_pkg;

  localparam int DEF_NEIGHBOR_DEPTH = 256;
  localparam int DEF_ROUTE_DEPTH    = 256;

  localparam logic [47:0] ADDR_ALL_ONES = 48'hFFFF_FFFF_FFFF;

  // reset values of the configuration registers
  localparam logic [7:0] DEF_SUCCESS_WEIGHT = 8'd205;
  localparam logic [7:0] DEF_RANDOM_WEIGHT  = 8'd51;

  // configuration register indexes
  localparam logic [1:0] CFG_LOCAL_ADDRESS  = 2'd0;
  localparam logic [1:0] CFG_SUCCESS_WEIGHT = 2'd1;
  localparam logic [1:0] CFG_RANDOM_WEIGHT  = 2'd2;

  // operation codes
  localparam logic [1:0] OP_HELLO  = 2'd0;
  localparam logic [1:0] OP_ROUTE  = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  // result status codes
  localparam logic [2:0] ST_IGNORED    = 3'd0;
  localparam logic [2:0] ST_UPDATED    = 3'd1;
  localparam logic [2:0] ST_ADDED      = 3'd2;
  localparam logic [2:0] ST_NEIGH_FULL = 3'd3;
  localparam logic [2:0] ST_ROUTE_FULL = 3'd4;
  localparam logic [2:0] ST_HIT        = 3'd5;
  localparam logic [2:0] ST_MISS       = 3'd6;

  // packet loss grading
  localparam logic [7:0] LOSS_MAX    = 8'hFF;
  localparam logic [7:0] GAP_LIMIT   = 8'h10;
  localparam logic [7:0] SUCCESS_MAX = 8'hFF;
  localparam logic [7:0] DIST_MAX    = 8'hFF;

  localparam int DIV_STEPS = 16;

  typedef struct packed {
    logic [1:0]  op;
    logic [47:0] source_address;
    logic [7:0]  sequence_req;
    logic [7:0]  randomness;
    logic [47:0] advertised_destination;
    logic [7:0]  advertised_distance;
    logic [7:0]  advertised_metric;
    logic [7:0]  protocol;
    logic [7:0]  protocol_addr;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  neighbor_index;
    logic [7:0]  route_index;
    logic [7:0]  metric_out;
    logic [47:0] found_destination;
  } out_item_t;

  typedef struct packed {
    logic [47:0] local_address;
    logic [7:0]  success_weight;
    logic [7:0]  random_weight;
  } cfg_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_NSTEP,
    CMD_HMUL,
    CMD_HWRITE,
    CMD_BMUL,
    CMD_DIVINIT,
    CMD_DIVSTEP,
    CMD_BSET,
    CMD_PSTEP,
    CMD_LSTEP
  } dp_cmd_t;

  typedef struct packed {
    logic n_hit;
    logic n_miss;
    logic n_full;
    logic local_eq;
    logic div_done;
    logic r_done;
  } dp_stat_t;

endpackage

// ----- rtl/mrtl_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module mrtl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/mrtl_ctrl.sv -----
// sequencing state machine of the mesh route table learner
// depends on mrtl_pkg; drives datapath commands from datapath status
module mrtl_ctrl
  import mrtl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  input  logic       out_stall,
  input  dp_stat_t   stat,
  output logic       in_stall,
  output logic       out_valid,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_NSCAN, S_HMUL, S_HWRITE, S_BMUL, S_DIVINIT, S_DIV,
    S_BSET, S_PLACE, S_PSCAN, S_LOOK, S_OUT
  } state_t;

  state_t     state, state_next;
  logic [1:0] op, op_next;

  always_comb begin
    state_next = state;
    op_next    = op;
    cmd        = CMD_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd     = CMD_LOAD;
          op_next = in_op;
          if (in_op == OP_HELLO || in_op == OP_ROUTE) begin
            state_next = S_NSCAN;
          end else if (in_op == OP_LOOKUP) begin
            state_next = S_LOOK;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_NSCAN: begin
        cmd = CMD_NSTEP;
        if (stat.n_hit || stat.n_miss) begin
          if (op == OP_ROUTE) begin
            state_next = S_BMUL;
          end else if (stat.n_miss && stat.n_full) begin
            state_next = S_OUT;
          end else begin
            state_next = S_HMUL;
          end
        end
      end
      S_HMUL: begin
        cmd        = CMD_HMUL;
        state_next = S_HWRITE;
      end
      S_HWRITE: begin
        cmd        = CMD_HWRITE;
        state_next = S_PLACE;
      end
      S_BMUL: begin
        cmd        = CMD_BMUL;
        state_next = S_DIVINIT;
      end
      S_DIVINIT: begin
        cmd        = CMD_DIVINIT;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_BSET;
        end else begin
          cmd = CMD_DIVSTEP;
        end
      end
      S_BSET: begin
        cmd        = CMD_BSET;
        state_next = S_PLACE;
      end
      S_PLACE: begin
        state_next = stat.local_eq ? S_OUT : S_PSCAN;
      end
      S_PSCAN: begin
        cmd = CMD_PSTEP;
        if (stat.r_done) begin
          state_next = S_OUT;
        end
      end
      S_LOOK: begin
        cmd = CMD_LSTEP;
        if (stat.r_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_NOP;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  // no transaction is taken while reset is held
  assign in_stall  = rst || (state != S_IDLE);
  assign out_valid = (state == S_OUT);

endmodule

// ----- rtl/mrtl_dp.sv -----
// datapath: neighbor and route tables, table scans, metric arithmetic, divider
// depends on mrtl_pkg and mrtl_ram; commanded by mrtl_ctrl
module mrtl_dp
  import mrtl_pkg::*;
#(
  parameter int NEIGHBOR_DEPTH = DEF_NEIGHBOR_DEPTH,
  parameter int ROUTE_DEPTH    = DEF_ROUTE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  dp_cmd_t   cmd,
  input  in_item_t  in_item,
  input  cfg_t      cfg,
  output dp_stat_t  stat,
  output out_item_t out_item
);

  localparam int NIW = $clog2(NEIGHBOR_DEPTH);
  localparam int NCW = $clog2(NEIGHBOR_DEPTH + 1);
  localparam int RIW = $clog2(ROUTE_DEPTH);
  localparam int RCW = $clog2(ROUTE_DEPTH + 1);

  in_item_t item;

  // neighbor word: address above info; route word: dest, next hop, info
  logic           n_we;
  logic [NIW-1:0] n_waddr;
  logic [87:0]    n_wdata, n_rdata;
  logic           r_we;
  logic [RIW-1:0] r_waddr;
  logic [127:0]   r_wdata, r_rdata;

  logic [NCW-1:0] ncount, nrd;
  logic           npv, nfound;
  logic [NIW-1:0] npidx, nslot;
  logic [39:0]    nold;

  logic [RCW-1:0] rcount, rrd;
  logic           rpv;
  logic [RIW-1:0] rpidx;

  logic [15:0] p1, p2;
  logic [7:0]  newsucc;
  logic [47:0] pdest, phop;
  logic [7:0]  pdist, pmetric;

  logic [15:0] quo;
  logic [7:0]  rem;
  logic [4:0]  dcnt;

  logic [2:0]  res_status;
  logic [7:0]  res_nidx, res_ridx, res_metric;
  logic [47:0] res_fdest;

  mrtl_ram #(.WIDTH(88), .DEPTH(NEIGHBOR_DEPTH)) u_nram (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(nrd[NIW-1:0]), .rdata(n_rdata)
  );

  mrtl_ram #(.WIDTH(128), .DEPTH(ROUTE_DEPTH)) u_rram (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(rrd[RIW-1:0]), .rdata(r_rdata)
  );

  // scan compares
  logic n_hit, n_miss, n_full, r_hit, r_miss, r_accept, l_hit, r_room;
  assign n_hit  = npv && (n_rdata[87:40] == item.source_address);
  assign n_miss = !npv && (nrd >= ncount);
  assign n_full = (ncount == NCW'(NEIGHBOR_DEPTH));
  assign r_hit  = rpv && (r_rdata[127:80] == pdest);
  assign r_miss = !rpv && (rrd >= rcount);
  assign r_room = (rcount < RCW'(ROUTE_DEPTH));
  assign r_accept = (r_rdata[79:32] == phop) || (pdist < r_rdata[7:0]) ||
                    ((pdist == r_rdata[7:0]) && (pmetric > r_rdata[15:8]));
  assign l_hit  = rpv && (r_rdata[23:16] == item.protocol) &&
                  (r_rdata[31:24] == item.protocol_addr);

  // hello grading
  logic [7:0] gap, succ_e, loss;
  assign gap    = item.sequence_req - nold[7:0];
  assign succ_e = (gap == 8'd0) ? SUCCESS_MAX : nold[15:8];
  always_comb begin
    if (gap <= 8'd1) begin
      loss = 8'd0;
    end else if (gap < GAP_LIMIT) begin
      loss = {gap[3:0], 4'd0};
    end else begin
      loss = LOSS_MAX;
    end
  end

  logic [16:0] nsum;
  logic [7:0]  hmetric;
  assign nsum    = {1'b0, p1} + {1'b0, p2};
  assign hmetric = nsum[16] ? 8'hFF : nsum[15:8];

  // route entry distance
  logic [7:0] bdist, bdm1;
  assign bdist = (item.advertised_distance == DIST_MAX) ? DIST_MAX
                                                         : item.advertised_distance + 8'd1;
  assign bdm1  = bdist - 8'd1;

  logic [8:0] dshift;
  logic [8:0] dtrial;
  assign dshift = {rem, quo[15]};
  assign dtrial = dshift - {1'b0, pdist};

  // table writes
  assign n_we    = (cmd == CMD_HWRITE);
  assign n_waddr = nslot;
  assign n_wdata = {item.source_address, item.protocol_addr, item.protocol,
                    hmetric, newsucc, item.sequence_req};
  assign r_we    = (cmd == CMD_PSTEP) && ((r_hit && r_accept) || (r_miss && r_room));
  assign r_waddr = r_hit ? rpidx : rcount[RIW-1:0];
  assign r_wdata = {pdest, phop, item.protocol_addr, item.protocol, pmetric, pdist};

  always_ff @(posedge clk) begin
    if (rst) begin
      ncount <= '0;
      rcount <= '0;
      nrd    <= '0;
      rrd    <= '0;
      npv    <= 1'b0;
      rpv    <= 1'b0;
    end else begin
      case (cmd)
        CMD_LOAD: begin
          item       <= in_item;
          nrd        <= '0;
          npv        <= 1'b0;
          rrd        <= '0;
          rpv        <= 1'b0;
          nfound     <= 1'b0;
          res_status <= ST_IGNORED;
          res_nidx   <= 8'd0;
          res_ridx   <= 8'd0;
          res_metric <= 8'd0;
          res_fdest  <= ADDR_ALL_ONES;
        end
        CMD_NSTEP: begin
          if (nrd < ncount) begin
            npv   <= 1'b1;
            npidx <= nrd[NIW-1:0];
            nrd   <= nrd + NCW'(1);
          end else begin
            npv <= 1'b0;
          end
          if (n_hit) begin
            nfound <= 1'b1;
            nslot  <= npidx;
            nold   <= n_rdata[39:0];
          end else if (n_miss) begin
            nfound <= 1'b0;
            nslot  <= ncount[NIW-1:0];
            nold   <= '0;
            if (item.op == OP_HELLO && n_full) begin
              res_status <= ST_NEIGH_FULL;
            end
          end
        end
        CMD_HMUL: begin
          p1      <= succ_e * cfg.success_weight;
          p2      <= item.randomness * cfg.random_weight;
          newsucc <= (succ_e > loss) ? succ_e - loss : 8'd0;
        end
        CMD_HWRITE: begin
          res_metric <= hmetric;
          pmetric    <= hmetric;
          pdist      <= 8'd1;
          pdest      <= item.source_address;
          phop       <= item.source_address;
          res_status <= nfound ? ST_UPDATED : ST_ADDED;
          res_nidx   <= 8'(nslot);
          if (!nfound) begin
            ncount <= ncount + NCW'(1);
          end
        end
        CMD_BMUL: begin
          p1       <= item.advertised_metric * bdm1;
          pdist    <= bdist;
          res_nidx <= nfound ? 8'(nslot) : 8'd0;
        end
        CMD_DIVINIT: begin
          quo  <= p1 + {8'd0, nold[23:16]};
          rem  <= 8'd0;
          dcnt <= 5'(DIV_STEPS);
        end
        CMD_DIVSTEP: begin
          if (!dtrial[8]) begin
            rem <= dtrial[7:0];
            quo <= {quo[14:0], 1'b1};
          end else begin
            rem <= dshift[7:0];
            quo <= {quo[14:0], 1'b0};
          end
          dcnt <= dcnt - 5'd1;
        end
        CMD_BSET: begin
          pmetric    <= quo[7:0];
          res_metric <= quo[7:0];
          pdest      <= item.advertised_destination;
          phop       <= item.source_address;
        end
        CMD_PSTEP, CMD_LSTEP: begin
          if (rrd < rcount) begin
            rpv   <= 1'b1;
            rpidx <= rrd[RIW-1:0];
            rrd   <= rrd + RCW'(1);
          end else begin
            rpv <= 1'b0;
          end
          if (cmd == CMD_PSTEP) begin
            if (r_hit) begin
              if (r_accept) begin
                res_ridx <= 8'(rpidx);
                if (item.op == OP_ROUTE) begin
                  res_status <= ST_UPDATED;
                end
              end
            end else if (r_miss) begin
              if (r_room) begin
                res_ridx <= 8'(rcount[RIW-1:0]);
                rcount   <= rcount + RCW'(1);
                if (item.op == OP_ROUTE) begin
                  res_status <= ST_ADDED;
                end
              end else if (item.op == OP_ROUTE) begin
                res_status <= ST_ROUTE_FULL;
              end
            end
          end else begin
            if (l_hit) begin
              res_status <= ST_HIT;
              res_ridx   <= 8'(rpidx);
              res_metric <= r_rdata[15:8];
              res_fdest  <= r_rdata[127:80];
            end else if (r_miss) begin
              res_status <= ST_MISS;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    stat.n_hit    = n_hit;
    stat.n_miss   = n_miss;
    stat.n_full   = n_full;
    stat.local_eq = (pdest == cfg.local_address);
    stat.div_done = (dcnt == 5'd0);
    stat.r_done   = (cmd == CMD_LSTEP) ? (l_hit || r_miss) : (r_hit || r_miss);
  end

  assign out_item = '{status: res_status, neighbor_index: res_nidx,
                      route_index: res_ridx, metric_out: res_metric,
                      found_destination: res_fdest};

`ifndef SYNTHESIS
  a_ncount_bound: assert property (@(posedge clk) disable iff (rst)
    ncount <= NCW'(NEIGHBOR_DEPTH))
    else $error("neighbor count beyond table depth");

  a_rcount_step: assert property (@(posedge clk) disable iff (rst)
    (rcount == $past(rcount)) || (rcount == $past(rcount) + RCW'(1)))
    else $error("route count moved by more than one");

  a_route_write_once: assert property (@(posedge clk) disable iff (rst)
    r_we |=> !r_we)
    else $error("route table written twice for one transaction");
`endif

endmodule

// ----- rtl/mesh_route_table_learner.sv -----
// top level of the mesh route table learner: config registers, controller, datapath
// depends on mrtl_pkg, mrtl_ctrl, mrtl_dp (and mrtl_ram below it)
//
// usage
//   input channel in_valid/in_stall carries one in_item_t per transaction:
//   hello (learn a neighbor and offer a one-hop route), route entry
//   (learn an advertised route), lookup by protocol key, or no operation
//   every transaction gives exactly one out_item_t on out_valid/out_stall
//   one transaction at a time: in_stall stays high from acceptance until
//   the result has been taken
//   transaction time is set by the linear table scans (one ram read per
//   entry) and a 16-step radix-2 divider for the hop blend
//   config writes (cfg_we, cfg_index, cfg_data) are taken at any edge and
//   belong between transactions
//   reset clears both table fill counts and reloads the weights; table
//   contents need no clearing since only filled entries are read
//   a stalled result simply waits in the output register
module mesh_route_table_learner
  import mrtl_pkg::*;
#(
  parameter int NEIGHBOR_DEPTH = DEF_NEIGHBOR_DEPTH,
  parameter int ROUTE_DEPTH    = DEF_ROUTE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // configuration registers, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.local_address  <= '0;
      cfg.success_weight <= DEF_SUCCESS_WEIGHT;
      cfg.random_weight  <= DEF_RANDOM_WEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOCAL_ADDRESS:  cfg.local_address  <= cfg_data;
        CFG_SUCCESS_WEIGHT: cfg.success_weight <= cfg_data[7:0];
        CFG_RANDOM_WEIGHT:  cfg.random_weight  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  mrtl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_op     (in_item.op),
    .out_stall (out_stall),
    .stat      (stat),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // tables, scans and arithmetic; the result register lives here too
  mrtl_dp #(
    .NEIGHBOR_DEPTH (NEIGHBOR_DEPTH),
    .ROUTE_DEPTH    (ROUTE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_item  (in_item),
    .cfg      (cfg),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule
